// ----- hw/rtl/dmsq_pkg.sv -----
// Shared types, widths and constants of the decimal middle-square generator.
// Depends on nothing; used by the controller, datapath, divider and top level.
package dmsq_pkg;

    localparam int unsigned VALUE_W  = 27;            // n-digit value, n <= 8
    localparam int unsigned SQ_W     = 2 * VALUE_W;   // full square
    localparam int unsigned DC_W     = 4;             // digit_count register
    localparam int unsigned DIV_STEPS = SQ_W;         // one quotient bit per cycle
    localparam int unsigned CNT_W    = $clog2(DIV_STEPS + 1);

    localparam logic [DC_W-1:0] DC_RESET = 4'd4;
    localparam logic [DC_W-1:0] DC_MIN   = 4'd2;
    localparam logic [DC_W-1:0] DC_CAP   = 4'd8;

    // Dividend source for the shared divider
    typedef enum logic [1:0] {
        SRC_SEED   = 2'd0,   // seed / 10^n, keep remainder
        SRC_SQUARE = 2'd1,   // square / 10^(n/2), keep quotient
        SRC_QUOT   = 2'd2    // quotient / 10^n, keep remainder
    } dmsq_src_t;

    typedef struct packed {
        logic      accept;    // capture request, digit count and square
        logic      div_load;  // load divider operands
        dmsq_src_t src;       // which dividend and divisor to load
        logic      div_step;  // one restoring-division iteration
        logic      commit;    // store remainder as new value and present it
    } dmsq_cmd_t;

    typedef struct packed {
        logic reseed;         // captured request is a reseed
    } dmsq_sts_t;

    function automatic logic [VALUE_W-1:0] pow10(input logic [DC_W-1:0] e);
        logic [VALUE_W-1:0] p;
        case (e)
            4'd0:    p = 27'd1;
            4'd1:    p = 27'd10;
            4'd2:    p = 27'd100;
            4'd3:    p = 27'd1000;
            4'd4:    p = 27'd10000;
            4'd5:    p = 27'd100000;
            4'd6:    p = 27'd1000000;
            4'd7:    p = 27'd10000000;
            4'd8:    p = 27'd100000000;
            default: p = 27'd1;
        endcase
        return p;
    endfunction

endpackage

// ----- hw/rtl/dmsq_div.sv -----
// Bit-serial restoring divider: 54-bit dividend by 27-bit divisor.
// Depends on dmsq_pkg for widths.
module dmsq_div (
    input  logic                          clk,
    input  logic                          load,
    input  logic                          step,
    input  logic [dmsq_pkg::SQ_W-1:0]     dividend,
    input  logic [dmsq_pkg::VALUE_W-1:0]  divisor,
    output logic [dmsq_pkg::SQ_W-1:0]     quotient,
    output logic [dmsq_pkg::VALUE_W-1:0]  remainder
);
    import dmsq_pkg::*;

    logic [SQ_W-1:0]    dq_reg;
    logic [SQ_W-1:0]    dq_next;
    logic [VALUE_W-1:0] rem_reg;
    logic [VALUE_W-1:0] rem_next;
    logic [VALUE_W-1:0] dvs_reg;
    logic [VALUE_W-1:0] dvs_next;
    logic [VALUE_W:0]   trial;
    logic               fits;

    // Shift the next dividend bit into the partial remainder; subtract if it fits
    assign trial = {rem_reg, dq_reg[SQ_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        dq_next  = dq_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        if (load)
        begin
            dq_next  = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (step)
        begin
            dq_next = {dq_reg[SQ_W-2:0], fits};
            if (fits)
                rem_next = VALUE_W'(trial - {1'b0, dvs_reg});
            else
                rem_next = trial[VALUE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = dq_reg;
    assign remainder = rem_reg;

endmodule

// ----- hw/rtl/dmsq_datapath.sv -----
// Datapath: digit-count register, value register, squarer, divider and output register.
// Depends on dmsq_pkg and dmsq_div.
module dmsq_datapath #(
    parameter int unsigned MAX_DIGITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [dmsq_pkg::DC_W-1:0]     cfg_data,
    input  logic                          command,
    input  logic [dmsq_pkg::VALUE_W-1:0]  seed_in,
    input  dmsq_pkg::dmsq_cmd_t           cmd,
    output dmsq_pkg::dmsq_sts_t           sts,
    output logic [dmsq_pkg::VALUE_W-1:0]  value_out
);
    import dmsq_pkg::*;

    localparam logic [DC_W-1:0] DIGIT_LIM =
        (MAX_DIGITS > 8) ? DC_CAP : DC_W'(MAX_DIGITS);

    logic [DC_W-1:0]    dc_reg;
    logic [DC_W-1:0]    n_reg;
    logic [DC_W-1:0]    n_eff;
    logic               reseed_reg;
    logic [VALUE_W-1:0] seed_reg;
    logic [VALUE_W-1:0] cur_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic [VALUE_W-1:0] out_reg;
    logic [SQ_W-1:0]    div_dividend;
    logic [VALUE_W-1:0] div_divisor;
    logic [SQ_W-1:0]    div_quot;
    logic [VALUE_W-1:0] div_rem;

    // Even digit count: at most DIGIT_LIM rounded down to even, and at least 2
    always_comb
    begin
        n_eff = dc_reg & 4'hE;
        if (n_eff > DIGIT_LIM)
            n_eff = DIGIT_LIM;
        n_eff = n_eff & 4'hE;
        if (n_eff < DC_MIN)
            n_eff = DC_MIN;
    end

    always_comb
    begin
        case (cmd.src)
            SRC_SEED:
            begin
                div_dividend = {{(SQ_W-VALUE_W){1'b0}}, seed_reg};
                div_divisor  = pow10(n_reg);
            end
            SRC_SQUARE:
            begin
                div_dividend = sq_reg;
                div_divisor  = pow10({1'b0, n_reg[DC_W-1:1]});
            end
            SRC_QUOT:
            begin
                div_dividend = div_quot;
                div_divisor  = pow10(n_reg);
            end
            default:
            begin
                div_dividend = sq_reg;
                div_divisor  = pow10(n_reg);
            end
        endcase
    end

    dmsq_div u_div (
        .clk       (clk),
        .load      (cmd.div_load),
        .step      (cmd.div_step),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_reg  <= DC_RESET;
            cur_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                dc_reg <= cfg_data;
            if (cmd.commit)
                cur_reg <= div_rem;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            n_reg      <= n_eff;
            reseed_reg <= command;
            seed_reg   <= seed_in;
            sq_reg     <= SQ_W'(cur_reg) * SQ_W'(cur_reg);
        end
        if (cmd.commit)
            out_reg <= div_rem;
    end

    assign sts.reseed = reseed_reg;
    assign value_out  = out_reg;

endmodule

// ----- hw/rtl/dmsq_ctrl.sv -----
// Controller state machine: request handshake, division sequencing, result handshake.
// Depends on dmsq_pkg for command and status types.
module dmsq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output dmsq_pkg::dmsq_cmd_t  cmd,
    input  dmsq_pkg::dmsq_sts_t  sts
);
    import dmsq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_LOAD2,
        S_COMMIT
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             pass2_reg;
    logic             pass2_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pass2_next     = pass2_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.src        = SRC_SEED;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    pass2_next = 1'b0;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.div_load = 1'b1;
                cmd.src      = sts.reseed ? SRC_SEED : SRC_SQUARE;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    if (sts.reseed || pass2_reg)
                        state_next = S_COMMIT;
                    else
                        state_next = S_LOAD2;
                end
            end
            S_LOAD2:
            begin
                cmd.div_load = 1'b1;
                cmd.src      = SRC_QUOT;
                cnt_next     = '0;
                pass2_next   = 1'b1;
                state_next   = S_DIV;
            end
            S_COMMIT:
            begin
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            pass2_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pass2_reg     <= pass2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- hw/rtl/decimal_middle_square_prng_unit.sv -----
// Top level of the decimal middle-square generator.
// Depends on dmsq_pkg, dmsq_ctrl, dmsq_datapath and dmsq_div.
//
// Usage:
//   Request channel (in_valid / in_stall, command, seed_in): a request is taken
//   at a rising edge with in_valid high and in_stall low. command = 0 steps the
//   generator, command = 1 reseeds it with seed_in reduced modulo 10^n.
//   Result channel (out_valid / out_stall, value_out): one result per request,
//   taken when out_valid is high and out_stall low.
//   Configuration channel (cfg_valid / cfg_ready, cfg_data): writes digit_count;
//   cfg_ready is always high. Write only while the block is idle.
// Timing:
//   One request at a time. A reseed runs one pass of the bit-serial divider
//   and a step runs two (square / 10^(n/2), then that quotient mod 10^n)
//   before the result is committed to the result register; the next request
//   can be taken in the cycle after that commit. The divider produces one
//   quotient bit a cycle.
// Reset: clears the value to zero, digit_count to 4, and drops any result.
// Stall: a finished result holds in the output register while out_stall is high;
//   a new request may already be taken, and its result waits for the slot.
module decimal_middle_square_prng_unit #(
    parameter int unsigned MAX_DIGITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dmsq_pkg::DC_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          command,
    input  logic [dmsq_pkg::VALUE_W-1:0]  seed_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [dmsq_pkg::VALUE_W-1:0]  value_out
);
    import dmsq_pkg::*;

    dmsq_cmd_t cmd;
    dmsq_sts_t sts;
    logic      cfg_we;

    // Configuration is always accepted; the register sits in the datapath
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    dmsq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    dmsq_datapath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .command   (command),
        .seed_in   (seed_in),
        .cmd       (cmd),
        .sts       (sts),
        .value_out (value_out)
    );

endmodule
